// ----- sv/balance_pid_motor_controller_top_assert.svh -----
// ----------------------------------------------------------------------------
// balance_pid_motor_controller_top_assert
// assertion macros shared by the balance controller rtl
// ----------------------------------------------------------------------------
`ifndef BALANCE_PID_MOTOR_CONTROLLER_TOP_ASSERT_SVH
`define BALANCE_PID_MOTOR_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define BPMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpmc assertion failed");

// next-cycle implication, held off during reset
`define BPMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpmc assertion failed");

`endif

// ----- sv/bpmc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpmc_pkg
// shared types, constants and tables of the balance controller
// ----------------------------------------------------------------------------
package bpmc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int NUM_ANGLES   = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < NUM_ANGLES) ? CORDIC_STEPS : NUM_ANGLES;
  localparam int ITER_W       = 5;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 19;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [MUL_P_W-1:0] mul_p_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PITCH_KP  = 3'd0,
    REG_PITCH_KI  = 3'd1,
    REG_PITCH_KD  = 3'd2,
    REG_YAW_KP    = 3'd3,
    REG_YAW_KI    = 3'd4,
    REG_TARGET    = 3'd5,
    REG_ACCEL_OFS = 3'd6,
    REG_GYRO_OFS  = 3'd7
  } cfg_reg_t;

  // pitch unit status toward the sequencer
  typedef struct packed {
    logic               done;
    logic signed [15:0] pitch;
  } cordic_res_t;

  // arctangent of 2^-i in degrees, q16
  function automatic logic signed [25:0] atan_q16(input logic [ITER_W-1:0] i);
    logic signed [25:0] v;
    case (i)
      5'd0:    v = 26'sd2949120;
      5'd1:    v = 26'sd1740967;
      5'd2:    v = 26'sd919879;
      5'd3:    v = 26'sd466945;
      5'd4:    v = 26'sd234379;
      5'd5:    v = 26'sd117304;
      5'd6:    v = 26'sd58666;
      5'd7:    v = 26'sd29335;
      5'd8:    v = 26'sd14668;
      5'd9:    v = 26'sd7334;
      5'd10:   v = 26'sd3667;
      5'd11:   v = 26'sd1833;
      5'd12:   v = 26'sd917;
      5'd13:   v = 26'sd458;
      5'd14:   v = 26'sd229;
      5'd15:   v = 26'sd115;
      5'd16:   v = 26'sd57;
      5'd17:   v = 26'sd29;
      5'd18:   v = 26'sd14;
      5'd19:   v = 26'sd7;
      5'd20:   v = 26'sd4;
      5'd21:   v = 26'sd2;
      5'd22:   v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/bpmc_mul.sv -----
// ----------------------------------------------------------------------------
// bpmc_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module bpmc_mul
  import bpmc_pkg::*;
(
  input  logic   clk,
  input  mul_a_t mul_a,
  input  mul_b_t mul_b,
  output mul_p_t mul_p
);

  mul_p_t prod_r;

  // one product per cycle, used by the sequencer in the next cycle
  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  assign mul_p = prod_r;

endmodule

// ----- sv/bpmc_cordic.sv -----
// ----------------------------------------------------------------------------
// bpmc_cordic
// iterative cordic vectoring, atan(y/x) in degrees q8
// ----------------------------------------------------------------------------
module bpmc_cordic
  import bpmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [23:0] y_in,
  input  logic signed [23:0] x_in,
  output cordic_res_t        res
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_DONE} cstate_t;

  cstate_t            state_r, state_nxt;
  logic [ITER_W-1:0]  iter_r, iter_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [25:0] z_r, z_nxt;
  logic               done_r, done_nxt;
  logic signed [15:0] pitch_r, pitch_nxt;

  logic signed [24:0] xa, ya;
  logic signed [33:0] dx, dy;
  logic signed [17:0] zq;

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    done_nxt  = 1'b0;
    pitch_nxt = pitch_r;
    // fold into the right half plane
    xa = x_in[23] ? -25'(x_in) : 25'(x_in);
    ya = x_in[23] ? -25'(y_in) : 25'(y_in);
    dx = y_r >>> iter_r;
    dy = x_r >>> iter_r;
    zq = 18'((z_r + 26'sd128) >>> 8);
    case (state_r)
      C_IDLE: begin
        if (start) begin
          iter_nxt = '0;
          x_nxt    = 34'(xa) <<< 6;
          y_nxt    = 34'(ya) <<< 6;
          z_nxt    = '0;
          state_nxt = C_RUN;
          // vertical vector: preload the ninety degree answer
          if (x_in == 24'sd0) begin
            if (y_in > 24'sd0)      z_nxt = 26'sd5898240;
            else if (y_in < 24'sd0) z_nxt = -26'sd5898240;
            state_nxt = C_DONE;
          end
        end
      end
      C_RUN: begin
        // one micro-rotation per cycle
        if (!y_r[33]) begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + atan_q16(iter_r);
        end else begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - atan_q16(iter_r);
        end
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_W'(CORDIC_ITERS - 1)) state_nxt = C_DONE;
      end
      C_DONE: begin
        // round to q8 and keep within plus or minus ninety
        if (zq > 18'sd23040)       pitch_nxt = 16'sd23040;
        else if (zq < -18'sd23040) pitch_nxt = -16'sd23040;
        else                       pitch_nxt = 16'(zq);
        done_nxt  = 1'b1;
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    iter_r  <= iter_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    pitch_r <= pitch_nxt;
  end

  assign res.done  = done_r;
  assign res.pitch = pitch_r;

endmodule

// ----- sv/balance_pid_motor_controller_top.sv -----
// ----------------------------------------------------------------------------
// balance_pid_motor_controller_top
// tilt-balance pid controller: imu word in, two motor compare values out
// ----------------------------------------------------------------------------
// in_tready is high only while the sequencer is idle, so a new word is not
// accepted before the last one is through. Each word is worked by the shared
// multiplier, which does all filter, divide-by-131, integrator and gain
// products one after another, and by the cordic unit, which turns one
// micro-rotation per cycle. A finished result sits in the output register,
// and the next word can be accepted while it waits for out_tready.
// ----------------------------------------------------------------------------
`include "balance_pid_motor_controller_top_assert.svh"

module balance_pid_motor_controller_top
  import bpmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  // input: accel_x_raw, accel_z_raw, gyro_y_raw, gyro_z_raw
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // output: left_compare[13:0], right_compare[27:14], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_FX, S_FZ, S_RY, S_RZ, S_RZC, S_CW, S_IP, S_IY,
    S_P0, S_P1, S_P2, S_P3, S_Y1, S_Y2, S_OUT
  } state_t;

  localparam logic signed [25:0] INTEG_LIMIT = 26'sd1966080;

  // fix the reciprocal quotient and apply the sign
  function automatic logic signed [17:0] rate_fix(input logic [24:0] n, input mul_p_t p,
                                                  input logic neg);
    logic [17:0] q;
    logic [25:0] qm;
    logic [25:0] r;
    q  = p[42:25];
    qm = 26'({q, 7'b0}) + 26'({q, 1'b0}) + 26'(q);
    r  = 26'(n) - qm;
    if (r >= 26'd131) q = q + 1'b1;
    return neg ? -$signed(q) : $signed(q);
  endfunction

  // q24 truncated toward zero, saturated to int16
  function automatic logic signed [15:0] drive16(input logic signed [47:0] v);
    logic [47:0] mag;
    logic [23:0] t;
    mag = v[47] ? 48'(-v) : 48'(v);
    t   = mag[47:24];
    if (!v[47]) return (t > 24'd32767) ? 16'sh7fff : 16'(t);
    if (t >= 24'd32768) return 16'sh8000;
    return -$signed({1'b0, t[14:0]});
  endfunction

  // integrator step with clamp
  function automatic logic signed [23:0] integ(input logic signed [23:0] i, input mul_p_t p);
    mul_p_t             rnd;
    logic signed [25:0] s;
    rnd = (p + MUL_P_W'(32768)) >>> 16;
    s   = 26'(i) + 26'(rnd);
    if (s > INTEG_LIMIT)  s = INTEG_LIMIT;
    if (s < -INTEG_LIMIT) s = -INTEG_LIMIT;
    return 24'(s);
  endfunction

  // configuration registers
  logic [15:0]        kp_r, ki_r, kd_r, kpy_r, kiy_r;
  logic signed [15:0] target_r;
  logic [31:0]        acc_ofs_r, gyro_ofs_r;

  // sequencer and datapath registers
  state_t             state_r, state_nxt;
  logic signed [16:0] ax_r, ax_nxt, az_r, az_nxt, gy_r, gy_nxt, gz_r, gz_nxt;
  logic signed [23:0] fx_r, fx_nxt, fz_r, fz_nxt;
  logic signed [23:0] ip_r, ip_nxt, iy_r, iy_nxt;
  logic signed [17:0] ry_r, ry_nxt, rz_r, rz_nxt;
  logic signed [16:0] err_r, err_nxt;
  logic signed [47:0] acc_r, acc_nxt;
  logic signed [15:0] pd_r, pd_nxt, yd_r, yd_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [13:0]        left_r, left_nxt, right_r, right_nxt;

  mul_a_t      mul_a;
  mul_b_t      mul_b;
  mul_p_t      mul_p;
  cordic_res_t cres;
  logic        cordic_start;

  logic [16:0]        gy_mag, gz_mag;
  logic [24:0]        ny, nz;
  mul_p_t             frnd;
  logic signed [47:0] pwide;
  logic signed [18:0] left_s, right_s;
  logic               in_acc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  bpmc_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  bpmc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .y_in  (fx_r),
    .x_in  (fz_r),
    .res   (cres)
  );

  // dividend for the rate: |g| * 256 + 65
  always_comb begin
    gy_mag = gy_r[16] ? 17'(-gy_r) : 17'(gy_r);
    gz_mag = gz_r[16] ? 17'(-gz_r) : 17'(gz_r);
    ny     = {gy_mag, 8'b0} + 25'd65;
    nz     = {gz_mag, 8'b0} + 25'd65;
    frnd   = (mul_p + MUL_P_W'(32768)) >>> 16;
    pwide  = 48'(mul_p);
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    az_nxt        = az_r;
    gy_nxt        = gy_r;
    gz_nxt        = gz_r;
    fx_nxt        = fx_r;
    fz_nxt        = fz_r;
    ip_nxt        = ip_r;
    iy_nxt        = iy_r;
    ry_nxt        = ry_r;
    rz_nxt        = rz_r;
    err_nxt       = err_r;
    acc_nxt       = acc_r;
    pd_nxt        = pd_r;
    yd_nxt        = yd_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mul_a         = '0;
    mul_b         = '0;
    cordic_start  = 1'b0;
    left_s        = 19'sd4910 - 19'(pd_r) - 19'(yd_r);
    right_s       = 19'sd4935 + 19'(pd_r) - 19'(yd_r);
    case (state_r)
      S_IDLE: begin
        // offset removal on the incoming word
        if (in_acc) begin
          ax_nxt = 17'($signed(in_tdata[15:0]))  - 17'($signed(acc_ofs_r[15:0]));
          az_nxt = 17'($signed(in_tdata[31:16])) - 17'($signed(acc_ofs_r[31:16]));
          gy_nxt = 17'($signed(in_tdata[47:32])) - 17'($signed(gyro_ofs_r[15:0]));
          gz_nxt = 17'($signed(in_tdata[63:48])) - 17'($signed(gyro_ofs_r[31:16]));
          state_nxt = S_FX;
        end
      end
      S_FX: begin
        mul_a = (MUL_A_W'(ax_r) <<< 6) - MUL_A_W'(fx_r);
        mul_b = 19'sd6554;
        state_nxt = S_FZ;
      end
      S_FZ: begin
        fx_nxt = fx_r + 24'(frnd);
        mul_a  = (MUL_A_W'(az_r) <<< 6) - MUL_A_W'(fz_r);
        mul_b  = 19'sd6554;
        state_nxt = S_RY;
      end
      S_RY: begin
        fz_nxt = fz_r + 24'(frnd);
        mul_a  = MUL_A_W'(ny);
        mul_b  = 19'sd256140;
        state_nxt = S_RZ;
      end
      S_RZ: begin
        ry_nxt = rate_fix(ny, mul_p, gy_r[16]);
        mul_a  = MUL_A_W'(nz);
        mul_b  = 19'sd256140;
        state_nxt = S_RZC;
      end
      S_RZC: begin
        rz_nxt       = rate_fix(nz, mul_p, gz_r[16]);
        cordic_start = 1'b1;
        state_nxt    = S_CW;
      end
      S_CW: begin
        if (cres.done) begin
          err_nxt   = 17'(target_r) - 17'(cres.pitch);
          state_nxt = S_IP;
        end
      end
      S_IP: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = 19'sd33554;
        state_nxt = S_IY;
      end
      S_IY: begin
        ip_nxt = integ(ip_r, mul_p);
        mul_a  = MUL_A_W'(rz_r);
        mul_b  = 19'sd33554;
        state_nxt = S_P0;
      end
      S_P0: begin
        iy_nxt = integ(iy_r, mul_p);
        mul_a  = MUL_A_W'(err_r);
        mul_b  = MUL_B_W'({1'b0, kp_r});
        state_nxt = S_P1;
      end
      S_P1: begin
        acc_nxt = pwide <<< 8;
        mul_a   = MUL_A_W'(ip_r);
        mul_b   = MUL_B_W'({1'b0, ki_r});
        state_nxt = S_P2;
      end
      S_P2: begin
        acc_nxt = acc_r + pwide;
        mul_a   = MUL_A_W'(ry_r);
        mul_b   = MUL_B_W'({1'b0, kd_r});
        state_nxt = S_P3;
      end
      S_P3: begin
        pd_nxt = drive16(acc_r - (pwide <<< 8));
        mul_a  = MUL_A_W'(rz_r);
        mul_b  = MUL_B_W'({1'b0, kpy_r});
        state_nxt = S_Y1;
      end
      S_Y1: begin
        acc_nxt = pwide <<< 8;
        mul_a   = MUL_A_W'(iy_r);
        mul_b   = MUL_B_W'({1'b0, kiy_r});
        state_nxt = S_Y2;
      end
      S_Y2: begin
        yd_nxt    = drive16(acc_r + pwide);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // load the output register once it is free
        if (!out_valid_r || out_tready) begin
          if (left_s < 19'sd1)         left_nxt = 14'd1;
          else if (left_s > 19'sd9819) left_nxt = 14'd9819;
          else                         left_nxt = 14'(left_s);
          if (right_s < 19'sd1)         right_nxt = 14'd1;
          else if (right_s > 19'sd9869) right_nxt = 14'd9869;
          else                          right_nxt = 14'(right_s);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, filter and integrator memory, registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fx_r        <= '0;
      fz_r        <= '0;
      ip_r        <= '0;
      iy_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fx_r        <= fx_nxt;
      fz_r        <= fz_nxt;
      ip_r        <= ip_nxt;
      iy_r        <= iy_nxt;
    end
    ax_r    <= ax_nxt;
    az_r    <= az_nxt;
    gy_r    <= gy_nxt;
    gz_r    <= gz_nxt;
    ry_r    <= ry_nxt;
    rz_r    <= rz_nxt;
    err_r   <= err_nxt;
    acc_r   <= acc_nxt;
    pd_r    <= pd_nxt;
    yd_r    <= yd_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r       <= 16'd23040;
      ki_r       <= 16'd0;
      kd_r       <= 16'd25600;
      kpy_r      <= 16'd1280;
      kiy_r      <= 16'd5120;
      target_r   <= 16'sd0;
      acc_ofs_r  <= 32'd0;
      gyro_ofs_r <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_PITCH_KP:  kp_r       <= cfg_wdata[15:0];
        REG_PITCH_KI:  ki_r       <= cfg_wdata[15:0];
        REG_PITCH_KD:  kd_r       <= cfg_wdata[15:0];
        REG_YAW_KP:    kpy_r      <= cfg_wdata[15:0];
        REG_YAW_KI:    kiy_r      <= cfg_wdata[15:0];
        REG_TARGET:    target_r   <= $signed(cfg_wdata[15:0]);
        REG_ACCEL_OFS: acc_ofs_r  <= cfg_wdata;
        REG_GYRO_OFS:  gyro_ofs_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, right_r, left_r};

  // checks
  `BPMC_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready)
  `BPMC_ASSERT_NOW(a_cordic_done_in_wait, cres.done, state_r == S_CW)
  `BPMC_ASSERT_NOW(a_left_range, out_tvalid,
    out_tdata[13:0] >= 14'd1 && out_tdata[13:0] <= 14'd9819)
  `BPMC_ASSERT_NOW(a_right_range, out_tvalid,
    out_tdata[27:14] >= 14'd1 && out_tdata[27:14] <= 14'd9869)

endmodule
